/* hdl/tcc_pkg.sv */
// ----------------------------------------------------------------------------
// tcc_pkg
// types and constants of the 16-bit timer/counter with compare
// ----------------------------------------------------------------------------
package tcc_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_ACK   = 2'd3
  } cmd_t;

  localparam logic [5:0] A_CTRLA    = 6'h00;
  localparam logic [5:0] A_CTRLB    = 6'h01;
  localparam logic [5:0] A_CTRLC    = 6'h02;
  localparam logic [5:0] A_INTCTRLA = 6'h06;
  localparam logic [5:0] A_INTCTRLB = 6'h07;
  localparam logic [5:0] A_CTRLFCLR = 6'h08;
  localparam logic [5:0] A_CTRLFSET = 6'h09;
  localparam logic [5:0] A_CTRLGCLR = 6'h0A;
  localparam logic [5:0] A_CTRLGSET = 6'h0B;
  localparam logic [5:0] A_INTFLAGS = 6'h0C;
  localparam logic [5:0] A_TEMP     = 6'h0F;

  localparam logic [2:0] MODE_FRQ      = 3'd1;
  localparam logic [2:0] MODE_DSTOP    = 3'd5;
  localparam logic [2:0] MODE_DSBOTTOM = 3'd7;

  localparam logic [1:0] FCMD_UPDATE  = 2'd1;
  localparam logic [1:0] FCMD_RESTART = 2'd2;
  localparam logic [1:0] FCMD_RESET   = 2'd3;

  function automatic logic [10:0] prescale(input logic [2:0] sel);
    logic [10:0] r;
    begin
      unique case (sel)
        3'd1: r = 11'd1;
        3'd2: r = 11'd2;
        3'd3: r = 11'd4;
        3'd4: r = 11'd8;
        3'd5: r = 11'd64;
        3'd6: r = 11'd256;
        3'd7: r = 11'd1024;
        default: r = 11'd0;
      endcase
      return r;
    end
  endfunction

endpackage

/* hdl/timer_counter_with_compare_top.sv */
// ----------------------------------------------------------------------------
// timer_counter_with_compare_top
// 16-bit timer/counter with period, four compare channels and buffering
// ----------------------------------------------------------------------------
// channel | tdata fields (low bit up)                         | bits
// in_     | command, address, write_data, vector              | 24
// out_    | read_data, flags, ovf..ccd_pending, count_value,  | 48
//         | counting_down                                     |
// one transaction per cycle unless the result stalls on out_tready: each item
// is handled in a single pass of logic between the state and result registers
// in_tready is high while the result register is empty or being taken
// synchronous active-low reset clears all timer state
module timer_counter_with_compare_top
  import tcc_pkg::*;
#(
  parameter int HAS_CD_CHANNELS = 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // command, address, write_data, vector
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_data, flags, ovf, err, cca, ccb, ccc,
                                  // ccd pending, count_value, counting_down
);

  logic [2:0]  clock_select_r, clock_select_nxt;
  logic [9:0]  divider_count_r, divider_count_nxt;
  logic [2:0]  wave_mode_r, wave_mode_nxt;
  logic [3:0]  compare_outputs_r, compare_outputs_nxt;
  logic [1:0]  control_f_r, control_f_nxt;
  logic [4:0]  buffer_valid_r, buffer_valid_nxt;
  logic [7:0]  int_flags_r, int_flags_nxt;
  logic [1:0]  int_levels_r [6];
  logic [1:0]  int_levels_nxt [6];
  logic [7:0]  temp_byte_r, temp_byte_nxt;
  logic [15:0] counter_r, counter_nxt;
  logic [15:0] period_r, period_nxt;
  logic [15:0] cmp_r [4];
  logic [15:0] cmp_nxt [4];
  logic [15:0] buf_r [5];
  logic [15:0] buf_nxt [5];
  logic        out_valid_r;
  logic [47:0] out_data_r;

  logic        accept;
  cmd_t        cmd;
  logic [5:0]  addr;
  logic [7:0]  wdata;
  logic [2:0]  vec;
  logic [7:0]  rd;
  logic [47:0] result;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign cmd        = cmd_t'(in_tdata[1:0]);
  assign addr       = in_tdata[7:2];
  assign wdata      = in_tdata[15:8];
  assign vec        = in_tdata[18:16];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    logic [15:0] top, cv, wide, wv;
    logic        ovf, load, isw, bsel, hit, step;
    logic [2:0]  widx;
    logic [10:0] dsum;
    logic [1:0]  fc;
    logic [7:0]  fb;
    clock_select_nxt    = clock_select_r;
    divider_count_nxt   = divider_count_r;
    wave_mode_nxt       = wave_mode_r;
    compare_outputs_nxt = compare_outputs_r;
    control_f_nxt       = control_f_r;
    buffer_valid_nxt    = buffer_valid_r;
    int_flags_nxt       = int_flags_r;
    int_levels_nxt      = int_levels_r;
    temp_byte_nxt       = temp_byte_r;
    counter_nxt         = counter_r;
    period_nxt          = period_r;
    cmp_nxt             = cmp_r;
    buf_nxt             = buf_r;
    rd                  = 8'd0;
    load                = 1'b0;
    ovf                 = 1'b0;
    hit                 = 1'b0;
    step                = 1'b0;
    cv                  = counter_r;
    dsum                = 11'(divider_count_r) + 11'd1;
    top                 = (wave_mode_r == MODE_FRQ) ? cmp_r[0] : period_r;
    fc                  = wdata[3:2];
    // wide register decode
    isw  = 1'b1;
    bsel = 1'b0;
    widx = 3'd0;
    wide = 16'd0;
    if (addr == 6'h20 || addr == 6'h21) begin
      wide = counter_r;
    end else if (addr == 6'h26 || addr == 6'h27) begin
      wide = period_r;
    end else if (addr >= 6'h28 && addr <= 6'h2F) begin
      widx = {1'b0, addr[2:1]};
      wide = cmp_r[addr[2:1]];
    end else if (addr >= 6'h36 && addr <= 6'h3F) begin
      bsel = 1'b1;
      widx = 3'((addr - 6'h36) >> 1);
      wide = buf_r[widx];
    end else begin
      isw = 1'b0;
    end
    wv = {wdata, temp_byte_r};

    unique case (cmd)
      CMD_READ: begin
        unique case (addr)
          A_CTRLA:    rd = {5'd0, clock_select_r};
          A_CTRLB:    rd = {5'd0, wave_mode_r};
          A_CTRLC:    rd = {4'd0, compare_outputs_r};
          A_INTCTRLA: rd = {4'd0, int_levels_r[1], int_levels_r[0]};
          A_INTCTRLB: rd = {int_levels_r[5], int_levels_r[4], int_levels_r[3],
                            int_levels_r[2]};
          A_CTRLFCLR, A_CTRLFSET: rd = {6'd0, control_f_r};
          A_CTRLGCLR, A_CTRLGSET: rd = {3'd0, buffer_valid_r};
          A_INTFLAGS: rd = int_flags_r;
          A_TEMP:     rd = temp_byte_r;
          default: begin
            if (isw) begin
              if (addr[0]) rd = temp_byte_r;
              else begin
                rd            = wide[7:0];
                temp_byte_nxt = wide[15:8];
              end
            end
          end
        endcase
      end
      CMD_WRITE: begin
        unique case (addr)
          A_CTRLA: begin
            if (!wdata[3]) begin
              clock_select_nxt = wdata[2:0];
              if (wdata[2:0] == 3'd0) divider_count_nxt = 10'd0;
            end
          end
          A_CTRLB: begin
            wave_mode_nxt = (wdata[2:0] == 3'd2 || wdata[2:0] == 3'd4) ? 3'd0
                                                                      : wdata[2:0];
          end
          A_CTRLC: compare_outputs_nxt = wdata[3:0];
          A_INTCTRLA: begin
            int_levels_nxt[0] = wdata[1:0];
            int_levels_nxt[1] = wdata[3:2];
          end
          A_INTCTRLB: begin
            int_levels_nxt[2] = wdata[1:0];
            int_levels_nxt[3] = wdata[3:2];
            if (HAS_CD_CHANNELS != 0) begin
              int_levels_nxt[4] = wdata[5:4];
              int_levels_nxt[5] = wdata[7:6];
            end
          end
          A_CTRLFCLR: control_f_nxt = control_f_r & ~wdata[1:0];
          A_CTRLFSET: begin
            control_f_nxt = control_f_r | wdata[1:0];
            if (fc == FCMD_UPDATE) load = 1'b1;
            else if (fc == FCMD_RESTART) begin
              control_f_nxt       = control_f_nxt & 2'b10;
              compare_outputs_nxt = 4'd0;
            end else if (fc == FCMD_RESET && clock_select_r == 3'd0) begin
              divider_count_nxt   = 10'd0;
              wave_mode_nxt       = 3'd0;
              compare_outputs_nxt = 4'd0;
              control_f_nxt       = 2'd0;
              buffer_valid_nxt    = 5'd0;
              int_flags_nxt       = 8'd0;
              temp_byte_nxt       = 8'd0;
              counter_nxt         = 16'd0;
              period_nxt          = 16'd0;
              for (int i = 0; i < 6; i++) int_levels_nxt[i] = 2'd0;
              for (int i = 0; i < 4; i++) cmp_nxt[i] = 16'd0;
              for (int i = 0; i < 5; i++) buf_nxt[i] = 16'd0;
            end
          end
          A_CTRLGCLR: buffer_valid_nxt = buffer_valid_r & ~wdata[4:0];
          A_CTRLGSET: buffer_valid_nxt = buffer_valid_r | wdata[4:0];
          A_INTFLAGS: int_flags_nxt = int_flags_r & ~wdata;
          A_TEMP:     temp_byte_nxt = wdata;
          default: begin
            if (isw) begin
              if (!addr[0]) temp_byte_nxt = wdata;
              else if (bsel) begin
                buf_nxt[widx]    = wv;
                buffer_valid_nxt = buffer_valid_r | 5'(5'd1 << widx);
              end else if (addr[5:1] == 5'h10) counter_nxt = wv;
              else if (addr[5:1] == 5'h13) period_nxt = wv;
              else cmp_nxt[widx[1:0]] = wv;
            end
          end
        endcase
      end
      CMD_TICK: begin
        if (clock_select_r != 3'd0) begin
          divider_count_nxt = dsum[9:0];
          if (dsum >= prescale(clock_select_r)) begin
            divider_count_nxt = 10'd0;
            step              = 1'b1;
            if (control_f_r[0]) begin
              cv = ((counter_r == 16'd0) ? top : counter_r) - 16'd1;
              hit = (cv == 16'd0);
              if (hit) begin
                ovf  = (wave_mode_r != MODE_DSTOP);
                load = 1'b1;
                if (wave_mode_r >= MODE_DSTOP) control_f_nxt[0] = 1'b0;
              end
            end else begin
              cv = ((counter_r == top) ? 16'd0 : counter_r) + 16'd1;
              hit = (cv == top);
              if (hit) begin
                ovf  = (wave_mode_r != MODE_DSBOTTOM);
                load = 1'b1;
                if (wave_mode_r >= MODE_DSTOP) control_f_nxt[0] = 1'b1;
              end
            end
            counter_nxt = cv;
            if (ovf) int_flags_nxt[0] = 1'b1;
          end
        end
      end
      CMD_ACK: begin
        unique case (vec)
          3'd0: int_flags_nxt[0] = 1'b0;
          3'd1: int_flags_nxt[1] = 1'b0;
          3'd2: int_flags_nxt[4] = 1'b0;
          3'd3: int_flags_nxt[5] = 1'b0;
          3'd4: int_flags_nxt[6] = 1'b0;
          3'd5: int_flags_nxt[7] = 1'b0;
          default: ;
        endcase
      end
      default: ;
    endcase

    // buffer load uses the buffers before this item
    if (load && !control_f_nxt[1]) begin
      if (buffer_valid_r[0]) period_nxt = buf_r[0];
      for (int i = 0; i < 4; i++)
        if (buffer_valid_r[i+1]) cmp_nxt[i] = buf_r[i+1];
      buffer_valid_nxt = 5'd0;
    end

    // compare against the values after any buffer load
    if (step) begin
      for (int i = 0; i < 4; i++) begin
        if ((i < 2 || HAS_CD_CHANNELS != 0) && cv == cmp_nxt[i])
          int_flags_nxt[4+i] = 1'b1;
      end
    end

    fb = int_flags_nxt;
    result = {3'd0, control_f_nxt[0], counter_nxt,
              fb[7] ? int_levels_nxt[5] : 2'd0,
              fb[6] ? int_levels_nxt[4] : 2'd0,
              fb[5] ? int_levels_nxt[3] : 2'd0,
              fb[4] ? int_levels_nxt[2] : 2'd0,
              fb[1] ? int_levels_nxt[1] : 2'd0,
              fb[0] ? int_levels_nxt[0] : 2'd0,
              fb, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_select_r    <= 3'd0;
      divider_count_r   <= 10'd0;
      wave_mode_r       <= 3'd0;
      compare_outputs_r <= 4'd0;
      control_f_r       <= 2'd0;
      buffer_valid_r    <= 5'd0;
      int_flags_r       <= 8'd0;
      temp_byte_r       <= 8'd0;
      counter_r         <= 16'd0;
      period_r          <= 16'd0;
      out_valid_r       <= 1'b0;
      for (int i = 0; i < 6; i++) int_levels_r[i] <= 2'd0;
      for (int i = 0; i < 4; i++) cmp_r[i] <= 16'd0;
      for (int i = 0; i < 5; i++) buf_r[i] <= 16'd0;
    end else begin
      if (accept) begin
        clock_select_r    <= clock_select_nxt;
        divider_count_r   <= divider_count_nxt;
        wave_mode_r       <= wave_mode_nxt;
        compare_outputs_r <= compare_outputs_nxt;
        control_f_r       <= control_f_nxt;
        buffer_valid_r    <= buffer_valid_nxt;
        int_flags_r       <= int_flags_nxt;
        temp_byte_r       <= temp_byte_nxt;
        counter_r         <= counter_nxt;
        period_r          <= period_nxt;
        int_levels_r      <= int_levels_nxt;
        cmp_r             <= cmp_nxt;
        buf_r             <= buf_nxt;
        out_valid_r       <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data_r <= result;
  end

  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r[15:8] == int_flags_r)
    else $error("flags in result differ from flag register");
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r[43:28] == counter_r && out_data_r[44] == control_f_r[0])
    else $error("count in result differs from counter");
  a_no_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(counter_r))
    else $error("state moved while result stalled");
  a_div_off: assert property (@(posedge clk) disable iff (!rst_n)
    clock_select_r == 3'd0 |-> divider_count_r == 10'd0 || $past(clock_select_r) != 3'd0)
    else $error("prescaler counts while timer off");

endmodule
